### hw/rtl/svm_pkg.sv
// shared types, constants and helpers of the spring mesh verlet step block
// depends on nothing; every module of the block imports it
`timescale 1ns / 1ps

package svm_pkg;

	localparam int DEF_MAX_GRID_WIDTH = 63;
	localparam int DATA_W = 32;
	localparam int DT_W   = 16;
	localparam int GW_W   = 6;
	localparam int SUM_W  = 40;
	localparam int ADDR_W = 1;
	localparam int CFG_W  = 16;

	localparam logic [DT_W-1:0] RESET_STEP_TIME  = 16'd655;
	localparam logic [GW_W-1:0] RESET_GRID_WIDTH = 6'd32;
	localparam logic [2*DT_W-1:0] RESET_DT_SQ =
		(2*DT_W)'(RESET_STEP_TIME) * (2*DT_W)'(RESET_STEP_TIME);

	// register indexes
	localparam logic [ADDR_W-1:0] REG_STEP_TIME  = 1'b0;
	localparam logic [ADDR_W-1:0] REG_GRID_WIDTH = 1'b1;

	// one column of the line store: both row banks and the half velocity
	typedef struct packed {
		logic signed [DATA_W-1:0] pos0;
		logic signed [DATA_W-1:0] pos1;
		logic signed [DATA_W-1:0] hvel;
	} col_t;

	typedef struct packed {
		logic wr;
		logic fwd;
		logic bwd;
	} cell_ctl_t;

	// operands of one result
	typedef struct packed {
		logic signed [DATA_W-1:0] centre;
		logic signed [DATA_W-1:0] up;
		logic signed [DATA_W-1:0] down;
		logic signed [DATA_W-1:0] left;
		logic signed [DATA_W-1:0] right;
		logic signed [DATA_W-1:0] hvel;
		logic                     done;
	} emit_req_t;

	typedef enum logic [1:0] {
		ST_RUN,
		ST_UPD,
		ST_FLUSH_A,
		ST_FLUSH_B
	} seq_state_t;

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] x);
		logic signed [DATA_W-1:0] r;
		if (x[SUM_W-1:DATA_W-1] == '0 || x[SUM_W-1:DATA_W-1] == '1) begin
			r = x[DATA_W-1:0];
		end else if (x[SUM_W-1]) begin
			r = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(DATA_W-1){1'b1}}};
		end
		return r;
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_pos(input col_t c, input logic b);
		return b ? c.pos1 : c.pos0;
	endfunction

endpackage

### hw/rtl/svm_cell.sv
// one column cell of the rotating line store ring
// depends on svm_pkg
`timescale 1ns / 1ps

module svm_cell import svm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  col_t      wr_data,
	input  col_t      from_next,
	input  col_t      from_prev,
	output col_t      col_q
);

	logic signed [DATA_W-1:0] pos0_q, pos1_q, hvel_q;
	col_t nxt;

	always_comb begin
		nxt = col_q;
		if (ctl.wr) begin
			nxt = wr_data;
		end else if (ctl.fwd) begin
			nxt = from_next;
		end else if (ctl.bwd) begin
			nxt = from_prev;
		end
	end

	// positions start at zero, border rows read zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos0_q <= '0;
			pos1_q <= '0;
		end else begin
			pos0_q <= nxt.pos0;
			pos1_q <= nxt.pos1;
		end
	end

	always_ff @(posedge clk) begin
		hvel_q <= nxt.hvel;
	end

	assign col_q = '{pos0: pos0_q, pos1: pos1_q, hvel: hvel_q};

endmodule

### hw/rtl/svm_emit.sv
// result pipeline: spring force, final velocity, output register
// depends on svm_pkg
`timescale 1ns / 1ps

module svm_emit import svm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [DT_W-1:0]          step_time,
	input  logic                     issue,
	input  emit_req_t                req,
	output logic                     rdy,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] new_position,
	output logic signed [DATA_W-1:0] new_velocity,
	output logic signed [DATA_W-1:0] new_force,
	output logic                     grid_done
);

	emit_req_t req_s1;
	logic vld_s1, vld_s2, vld_s3, vld_q;
	logic signed [DATA_W-1:0] force_s2, hvel_s2, pos_s2;
	logic signed [DATA_W-1:0] force_s3, hvel_s3, pos_s3;
	logic done_s2, done_s3;
	logic signed [DATA_W+DT_W:0] prod_s3, prod_rnd;
	logic signed [DATA_W-1:0] dv;
	logic signed [SUM_W-1:0] fsum;
	logic signed [DATA_W-1:0] pos_q, vel_q, force_q;
	logic done_q;

	// whole pipeline holds while the output register is blocked
	assign rdy = !vld_q || out_ready;

	assign fsum = SUM_W'(req_s1.up) + SUM_W'(req_s1.down) + SUM_W'(req_s1.left)
		+ SUM_W'(req_s1.right) - (SUM_W'(req_s1.centre) <<< 2);

	assign prod_rnd = prod_s3 + ((DATA_W+DT_W+1)'(1) <<< 16);
	assign dv = prod_rnd[DATA_W+DT_W:17];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_q  <= 1'b0;
		end else if (rdy) begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_q  <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy) begin
			req_s1   <= req;
			force_s2 <= sat32(fsum);
			hvel_s2  <= req_s1.hvel;
			pos_s2   <= req_s1.centre;
			done_s2  <= req_s1.done;
			prod_s3  <= (DATA_W+DT_W+1)'(force_s2)
				* (DATA_W+DT_W+1)'($signed({1'b0, step_time}));
			force_s3 <= force_s2;
			hvel_s3  <= hvel_s2;
			pos_s3   <= pos_s2;
			done_s3  <= done_s2;
			pos_q    <= pos_s3;
			vel_q    <= sat32(SUM_W'(hvel_s3) + SUM_W'(dv));
			force_q  <= force_s3;
			done_q   <= done_s3;
		end
	end

	assign out_valid    = vld_q;
	assign new_position = pos_q;
	assign new_velocity = vel_q;
	assign new_force    = force_q;
	assign grid_done    = done_q;

endmodule

### hw/rtl/spring_mesh_verlet_step.sv
// velocity verlet step over a mass-spring height grid: each cell is taken in ST_RUN
// and written back in ST_UPD, plus up to MAX_GRID_WIDTH/2 columns of ring rotation at
// each row end, one column per cycle. results trail the input by one row and pass the
// svm_emit registers s1, s2, s3 and the output register. a last cell flushes up to two
// rows of results, each once the ring reaches its column. reset zeroes both row banks.
// depends on svm_pkg, svm_cell, svm_emit
`timescale 1ns / 1ps

module spring_mesh_verlet_step import svm_pkg::*; #(
	parameter int MAX_GRID_WIDTH = DEF_MAX_GRID_WIDTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [DATA_W-1:0] position,
	input  logic signed [DATA_W-1:0] velocity,
	input  logic signed [DATA_W-1:0] force_req,
	input  logic                     last_cell,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] new_position,
	output logic signed [DATA_W-1:0] new_velocity,
	output logic signed [DATA_W-1:0] new_force,
	output logic                     grid_done,
	input  logic                     cfg_wr_en,
	input  logic [ADDR_W-1:0]        cfg_addr,
	input  logic [CFG_W-1:0]         cfg_wdata
);

	localparam int COL_W = $clog2(MAX_GRID_WIDTH);
	localparam int CMP_W = GW_W + 1;
	localparam int RIGHT_CELL = 2 % MAX_GRID_WIDTH;
	localparam logic [COL_W:0] MAX_D = (COL_W+1)'(MAX_GRID_WIDTH);
	localparam logic [COL_W:0] HALF_D = (COL_W+1)'(MAX_GRID_WIDTH / 2);
	localparam logic [COL_W-1:0] LAST_COL = COL_W'(MAX_GRID_WIDTH - 1);
	localparam logic [CMP_W-1:0] MAX_W = CMP_W'(MAX_GRID_WIDTH);

	logic [DT_W-1:0]   step_time_q;
	logic [GW_W-1:0]   grid_width_q;
	logic [2*DT_W-1:0] dt_sq_q;

	seq_state_t state_q, state_d;
	logic [COL_W-1:0] head_q, col_q, c_q, flush_col_q, tgt, tgt_run;
	logic first_row_q, bank_q;

	logic signed [DATA_W-1:0] p_s1, v_s1;
	logic signed [DATA_W+DT_W:0] pv_s1, pf_s1;
	logic signed [DATA_W+2*DT_W:0] pff_s1;
	logic last_s1;

	logic [CMP_W-1:0] weff;
	logic [COL_W:0] gap_raw, ring_gap;
	logic aligned, go_fwd;
	logic c_next_in, j_next_in, nxt_fwd;
	logic upd_go, fl_go, issue, emit_rdy;
	logic wr_at0, wr_at1, rot_fwd, rot_bwd;

	logic signed [DATA_W+DT_W:0] pv_rnd, pf_rnd;
	logic signed [DATA_W+2*DT_W:0] pff_rnd;
	logic signed [DATA_W:0] term_v;
	logic signed [DATA_W-1:0] term_f, term_ff;
	logic signed [DATA_W-1:0] pnew, vh;

	col_t ring_q [MAX_GRID_WIDTH];
	col_t c_left, c_mid, c_right, wcol;
	cell_ctl_t ctl [MAX_GRID_WIDTH];
	emit_req_t req;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_time_q  <= RESET_STEP_TIME;
			grid_width_q <= RESET_GRID_WIDTH;
			dt_sq_q      <= RESET_DT_SQ;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_addr)
					REG_STEP_TIME: begin
						step_time_q <= cfg_wdata[DT_W-1:0];
						dt_sq_q     <= (2*DT_W)'(cfg_wdata[DT_W-1:0])
							* (2*DT_W)'(cfg_wdata[DT_W-1:0]);
					end
					REG_GRID_WIDTH: grid_width_q <= cfg_wdata[GW_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		if (grid_width_q == '0) begin
			weff = CMP_W'(1);
		end else if (CMP_W'(grid_width_q) > MAX_W) begin
			weff = MAX_W;
		end else begin
			weff = CMP_W'(grid_width_q);
		end
	end

	assign tgt_run = (CMP_W'(col_q) >= weff) ? COL_W'(weff - CMP_W'(1)) : col_q;
	assign c_next_in = (CMP_W'(c_q) + CMP_W'(1)) < weff;
	assign j_next_in = (CMP_W'(flush_col_q) + CMP_W'(1)) < weff;
	assign nxt_fwd = c_next_in && !(last_s1 && first_row_q);

	always_comb begin
		case (state_q)
			ST_RUN:  tgt = tgt_run;
			ST_UPD:  tgt = c_q;
			default: tgt = flush_col_q;
		endcase
	end

	// shortest way round the ring
	assign aligned  = head_q == tgt;
	assign gap_raw  = {1'b0, tgt} - {1'b0, head_q};
	assign ring_gap = gap_raw[COL_W] ? gap_raw + MAX_D : gap_raw;
	assign go_fwd   = ring_gap <= HALF_D;

	// update arithmetic
	assign pv_rnd  = pv_s1 + ((DATA_W+DT_W+1)'(1) <<< 15);
	assign pf_rnd  = pf_s1 + ((DATA_W+DT_W+1)'(1) <<< 16);
	assign pff_rnd = pff_s1 + ((DATA_W+2*DT_W+1)'(1) <<< 32);
	assign term_v  = pv_rnd[DATA_W+DT_W:16];
	assign term_f  = pf_rnd[DATA_W+DT_W:17];
	assign term_ff = pff_rnd[DATA_W+2*DT_W:33];
	assign pnew = sat32(SUM_W'(p_s1) + SUM_W'(term_v) + SUM_W'(term_ff));
	assign vh   = sat32(SUM_W'(v_s1) + SUM_W'(term_f));

	assign c_left  = ring_q[0];
	assign c_mid   = ring_q[1];
	assign c_right = ring_q[RIGHT_CELL];

	always_comb begin
		wcol = c_mid;
		wcol.hvel = vh;
		if (bank_q) begin
			wcol.pos1 = pnew;
			if (first_row_q) wcol.pos0 = '0;
		end else begin
			wcol.pos0 = pnew;
			if (first_row_q) wcol.pos1 = '0;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_RUN: begin
				if (in_valid && aligned) state_d = ST_UPD;
			end
			ST_UPD: begin
				if (upd_go) begin
					if (!last_s1) begin
						state_d = ST_RUN;
					end else if (!first_row_q && c_next_in) begin
						state_d = ST_FLUSH_A;
					end else begin
						state_d = ST_FLUSH_B;
					end
				end
			end
			ST_FLUSH_A: begin
				if (fl_go && !j_next_in) state_d = ST_FLUSH_B;
			end
			ST_FLUSH_B: begin
				if (fl_go && flush_col_q == c_q) state_d = ST_RUN;
			end
			default: state_d = ST_RUN;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready = 1'b0;
		upd_go   = 1'b0;
		fl_go    = 1'b0;
		issue    = 1'b0;
		req      = '0;
		case (state_q)
			ST_RUN: begin
				in_ready = aligned;
			end
			ST_UPD: begin
				upd_go = first_row_q || emit_rdy;
				issue  = !first_row_q && emit_rdy;
				req.centre = pick_pos(c_mid, !bank_q);
				req.up     = pick_pos(c_mid, bank_q);
				req.down   = pnew;
				req.left   = (c_q != '0) ? pick_pos(c_left, !bank_q) : '0;
				req.right  = c_next_in ? pick_pos(c_right, !bank_q) : '0;
				req.hvel   = c_mid.hvel;
			end
			ST_FLUSH_A: begin
				fl_go = aligned && emit_rdy;
				issue = fl_go;
				req.centre = pick_pos(c_mid, !bank_q);
				req.up     = pick_pos(c_mid, bank_q);
				req.left   = pick_pos(c_left, !bank_q);
				req.right  = j_next_in ? pick_pos(c_right, !bank_q) : '0;
				req.hvel   = c_mid.hvel;
			end
			ST_FLUSH_B: begin
				fl_go = aligned && emit_rdy;
				issue = fl_go;
				req.centre = pick_pos(c_mid, bank_q);
				req.up     = pick_pos(c_mid, !bank_q);
				req.left   = (flush_col_q != '0) ? pick_pos(c_left, bank_q) : '0;
				req.right  = (flush_col_q < c_q) ? pick_pos(c_right, bank_q) : '0;
				req.hvel   = c_mid.hvel;
				req.done   = flush_col_q == c_q;
			end
			default: ;
		endcase
	end

	// moving on to the next column writes straight into the shifted slot
	assign wr_at1  = upd_go && !nxt_fwd;
	assign wr_at0  = upd_go && nxt_fwd;
	assign rot_fwd = (state_q == ST_UPD) ? wr_at0 : (!aligned && go_fwd);
	assign rot_bwd = (state_q != ST_UPD) && !aligned && !go_fwd;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			p_s1    <= position;
			v_s1    <= velocity;
			last_s1 <= last_cell;
			pv_s1   <= (DATA_W+DT_W+1)'(velocity)
				* (DATA_W+DT_W+1)'($signed({1'b0, step_time_q}));
			pf_s1   <= (DATA_W+DT_W+1)'(force_req)
				* (DATA_W+DT_W+1)'($signed({1'b0, step_time_q}));
			pff_s1  <= (DATA_W+2*DT_W+1)'(force_req)
				* (DATA_W+2*DT_W+1)'($signed({1'b0, dt_sq_q}));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			head_q      <= '0;
			col_q       <= '0;
			c_q         <= '0;
			flush_col_q <= '0;
			first_row_q <= 1'b1;
			bank_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (rot_fwd) begin
				head_q <= (head_q == LAST_COL) ? '0 : head_q + COL_W'(1);
			end else if (rot_bwd) begin
				head_q <= (head_q == '0) ? LAST_COL : head_q - COL_W'(1);
			end
			if (in_valid && in_ready) c_q <= tgt_run;
			if (upd_go) begin
				if (last_s1) begin
					flush_col_q <= nxt_fwd ? c_q + COL_W'(1) : '0;
				end else if (c_next_in) begin
					col_q <= c_q + COL_W'(1);
				end else begin
					col_q       <= '0;
					bank_q      <= !bank_q;
					first_row_q <= 1'b0;
				end
			end
			if (fl_go) begin
				if (state_q == ST_FLUSH_A) begin
					flush_col_q <= j_next_in ? flush_col_q + COL_W'(1) : '0;
				end else if (flush_col_q == c_q) begin
					col_q       <= '0;
					first_row_q <= 1'b1;
				end else begin
					flush_col_q <= flush_col_q + COL_W'(1);
				end
			end
		end
	end

	// ring of column cells; cell k holds column head-1+k
	for (genvar k = 0; k < MAX_GRID_WIDTH; k++) begin : g_ring
		if (k == 1) begin : g_w1
			assign ctl[k] = '{wr: wr_at1, fwd: rot_fwd, bwd: rot_bwd};
		end else if (k == 0) begin : g_w0
			assign ctl[k] = '{wr: wr_at0, fwd: rot_fwd, bwd: rot_bwd};
		end else begin : g_nw
			assign ctl[k] = '{wr: 1'b0, fwd: rot_fwd, bwd: rot_bwd};
		end
		svm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl[k]),
			.wr_data   (wcol),
			.from_next (ring_q[(k + 1) % MAX_GRID_WIDTH]),
			.from_prev (ring_q[(k + MAX_GRID_WIDTH - 1) % MAX_GRID_WIDTH]),
			.col_q     (ring_q[k])
		);
	end

	svm_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.step_time    (step_time_q),
		.issue        (issue),
		.req          (req),
		.rdy          (emit_rdy),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.new_position (new_position),
		.new_velocity (new_velocity),
		.new_force    (new_force),
		.grid_done    (grid_done)
	);

endmodule

### tb/tb_spring_mesh_verlet_step.sv
// testbench for spring_mesh_verlet_step: streams grids of cells and checks each result
// against an in-bench predictor of the verlet step; depends on svm_pkg and the block rtl
`timescale 1ns / 1ps

module tb_spring_mesh_verlet_step import svm_pkg::*; ();

	localparam int GRID_MAX = DEF_MAX_GRID_WIDTH;
	localparam int SETTLE_CYCLES = 300;

	typedef struct {
		logic signed [DATA_W-1:0] pos;
		logic signed [DATA_W-1:0] vel;
		logic signed [DATA_W-1:0] frc;
		logic                     done;
	} cell_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [DATA_W-1:0] position = '0;
	logic signed [DATA_W-1:0] velocity = '0;
	logic signed [DATA_W-1:0] force_req = '0;
	logic last_cell = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [DATA_W-1:0] new_position;
	logic signed [DATA_W-1:0] new_velocity;
	logic signed [DATA_W-1:0] new_force;
	logic grid_done;
	logic cfg_wr_en = 1'b0;
	logic [ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	// predictor copy of the block state
	longint row_pos[2][GRID_MAX];
	longint half_vel[GRID_MAX];
	int unsigned col_idx;
	bit first_row;
	bit cur_bank;
	int unsigned dt_reg;
	int unsigned width_reg;

	cell_result_t due_cells[$];
	int errors = 0;
	int idle_pct = 0;
	int stall_pct = 0;

	spring_mesh_verlet_step DUT (.*);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic longint round_shift(longint x, int s);
		return (x + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic longint clamp32(longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	function automatic void add_result(longint centre, longint up, longint down, longint left,
			longint right, longint hv, bit done);
		cell_result_t r;
		longint f;
		f = clamp32(up + down + left + right - 4 * centre);
		r.pos = centre[31:0];
		r.frc = f[31:0];
		f = clamp32(hv + round_shift(f * longint'(dt_reg), 17));
		r.vel = f[31:0];
		r.done = done;
		due_cells.push_back(r);
	endfunction

	function automatic void verlet_predict(logic signed [31:0] p_in, logic signed [31:0] v_in,
			logic signed [31:0] f_in, bit last);
		int unsigned w, c, j;
		bit prv;
		longint p, v, f, dt, pn, vh, left, right;
		w = (width_reg == 0) ? 1 : width_reg;
		if (col_idx >= w) col_idx = w - 1;
		c = col_idx;
		prv = ~cur_bank;
		p = p_in;
		v = v_in;
		f = f_in;
		dt = dt_reg;
		pn = clamp32(p + round_shift(v * dt, 16) + round_shift(f * (dt * dt), 33));
		vh = clamp32(v + round_shift(f * dt, 17));
		if (!first_row) begin
			left = (c > 0) ? row_pos[prv][c-1] : 0;
			right = (c + 1 < w) ? row_pos[prv][c+1] : 0;
			add_result(row_pos[prv][c], row_pos[cur_bank][c], pn, left, right, half_vel[c], 0);
		end else begin
			row_pos[prv][c] = 0;
		end
		row_pos[cur_bank][c] = pn;
		half_vel[c] = vh;
		if (last) begin
			// flush: tail of the row above, then the current row up to this column
			if (!first_row) begin
				for (j = c + 1; j < w; j++) begin
					right = (j + 1 < w) ? row_pos[prv][j+1] : 0;
					add_result(row_pos[prv][j], row_pos[cur_bank][j], 0, row_pos[prv][j-1],
						right, half_vel[j], 0);
				end
			end
			for (j = 0; j <= c; j++) begin
				left = (j > 0) ? row_pos[cur_bank][j-1] : 0;
				right = (j < c) ? row_pos[cur_bank][j+1] : 0;
				add_result(row_pos[cur_bank][j], row_pos[prv][j], 0, left, right, half_vel[j],
					j == c);
			end
			col_idx = 0;
			first_row = 1;
		end else if (c + 1 >= w) begin
			col_idx = 0;
			cur_bank = prv;
			first_row = 0;
		end else begin
			col_idx = c + 1;
		end
	endfunction

	// result checker and receiver stall
	always @(posedge clk) begin
		cell_result_t e;
		if (out_valid && out_ready) begin
			if (due_cells.size() == 0) begin
				$error("unexpected result: pos %0d vel %0d force %0d", new_position,
					new_velocity, new_force);
				errors++;
			end else begin
				e = due_cells.pop_front();
				if (new_position !== e.pos) begin
					$error("new_position expected %0d got %0d", e.pos, new_position);
					errors++;
				end
				if (new_velocity !== e.vel) begin
					$error("new_velocity expected %0d got %0d", e.vel, new_velocity);
					errors++;
				end
				if (new_force !== e.frc) begin
					$error("new_force expected %0d got %0d", e.frc, new_force);
					errors++;
				end
				if (grid_done !== e.done) begin
					$error("grid_done expected %0d got %0d", e.done, grid_done);
					errors++;
				end
			end
		end
		out_ready <= !(stall_pct > 0 && $urandom_range(99) < stall_pct);
	end

	task automatic send_cell(logic signed [31:0] p, logic signed [31:0] v,
			logic signed [31:0] f, bit last);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		in_valid <= 1'b1;
		position <= p;
		velocity <= v;
		force_req <= f;
		last_cell <= last;
		do @(posedge clk); while (!in_ready);
		verlet_predict(p, v, f, last);
	endtask

	task automatic write_reg(logic [ADDR_W-1:0] idx, int unsigned val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val[CFG_W-1:0];
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == REG_STEP_TIME) dt_reg = val & 32'hFFFF;
		else width_reg = val & 32'h3F;
	endtask

	// drain outstanding results, then let the block settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (due_cells.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return $urandom_range(0, 1 << 20) - (1 << 19);
			default: return $urandom;
		endcase
	endfunction

	task automatic run_grid(int cells);
		for (int i = 0; i < cells; i++)
			send_cell(pick_value(), pick_value(), pick_value(), i == cells - 1);
	endtask

	task automatic test_reset_config();
		run_grid(40);
		wait_idle();
	endtask

	task automatic test_directed();
		write_reg(REG_STEP_TIME, 65535);
		write_reg(REG_GRID_WIDTH, 3);
		send_cell(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
		send_cell(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
		send_cell(0, 0, 0, 0);
		send_cell(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0);
		send_cell(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0);
		send_cell(32'h0001_0000, -32'sh0001_0000, 32'h0000_8000, 0);
		send_cell(-1, 1, -1, 0);
		send_cell(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0);
		send_cell(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1);
		wait_idle();
		// zero width acts as one column, zero time step
		write_reg(REG_STEP_TIME, 0);
		write_reg(REG_GRID_WIDTH, 0);
		send_cell(32'h7FFF_FFFF, -1, 32'h8000_0000, 0);
		send_cell(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
		send_cell(32'h1234_5678, 32'h8765_4321, 32'hFFFF_0000, 1);
		wait_idle();
		// flush in the middle of the second row
		write_reg(REG_STEP_TIME, 1);
		write_reg(REG_GRID_WIDTH, 4);
		for (int i = 0; i < 6; i++) send_cell(pick_value(), pick_value(), pick_value(), i == 5);
		wait_idle();
		// single-cell grid flushed on its first row
		write_reg(REG_STEP_TIME, 32768);
		write_reg(REG_GRID_WIDTH, 2);
		send_cell(32'h4000_0000, 32'hC000_0000, 32'h7FFF_FFFF, 1);
		wait_idle();
	endtask

	task automatic test_random_phase(int sender_idle, int receiver_stall, int items);
		int sent, w, cells;
		idle_pct = sender_idle;
		stall_pct = receiver_stall;
		sent = 0;
		while (sent < items) begin
			case ($urandom_range(0, 7))
				0: write_reg(REG_STEP_TIME, 0);
				1: write_reg(REG_STEP_TIME, 65535);
				default: write_reg(REG_STEP_TIME, $urandom_range(0, 65535));
			endcase
			case ($urandom_range(0, 9))
				0: w = GRID_MAX;
				1: w = 0;
				default: w = $urandom_range(1, 8);
			endcase
			write_reg(REG_GRID_WIDTH, w);
			if (w == 0) w = 1;
			if (w == GRID_MAX) cells = $urandom_range(1, 2 * GRID_MAX);
			else cells = $urandom_range(1, 5 * w);
			run_grid(cells);
			sent += cells;
			wait_idle();
		end
		idle_pct = 0;
		stall_pct = 0;
	endtask

	initial begin
		for (int b = 0; b < 2; b++)
			for (int c = 0; c < GRID_MAX; c++) row_pos[b][c] = 0;
		for (int c = 0; c < GRID_MAX; c++) half_vel[c] = 0;
		col_idx = 0;
		first_row = 1;
		cur_bank = 0;
		dt_reg = RESET_STEP_TIME;
		width_reg = RESET_GRID_WIDTH;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_config();
		test_directed();
		test_random_phase(0, 0, 35);
		test_random_phase(87, 0, 35);
		test_random_phase(0, 87, 35);
		test_random_phase(8, 8, 35);
		if (errors == 0 && due_cells.size() == 0) begin
			$display("tb_spring_mesh_verlet_step: done, clean");
		end else begin
			$display("tb_spring_mesh_verlet_step: done, errors");
		end
		$finish;
	end

	initial begin
		#(12 * 2000000);
		$display("tb_spring_mesh_verlet_step: done, errors");
		$finish;
	end

endmodule

### files.f
hw/rtl/svm_pkg.sv
hw/rtl/svm_cell.sv
hw/rtl/svm_emit.sv
hw/rtl/spring_mesh_verlet_step.sv
tb/tb_spring_mesh_verlet_step.sv
